// ----- rtl/core/i2cra_pkg.sv -----
// shared types and constants for the i2c register access master
package i2cra_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_PAIR  = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        nack_seen;
    } t_out_item;

endpackage

// ----- rtl/core/i2cra_in_stage.sv -----
// input holding register between the request channel and the sequencer
module i2cra_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2cra_pkg::t_in_item i_item,
    input  logic                i_take,
    output logic                o_valid,
    output i2cra_pkg::t_in_item o_item
);

    logic                r_vld;
    i2cra_pkg::t_in_item r_item;

    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/core/i2cra_engine.sv -----
// bus sequencer: one half-bit slot per step, drives scl/sda and collects read bytes
module i2cra_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_fire,
    input  i2cra_pkg::t_in_item  i_item,
    output i2cra_pkg::t_out_item o_res
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_A = 4'd1,
        PH_START_B = 4'd2,
        PH_TX      = 4'd3,
        PH_TXACK_L = 4'd4,
        PH_TXACK_H = 4'd5,
        PH_RS_A    = 4'd6,
        PH_RS_B    = 4'd7,
        PH_RS_C    = 4'd8,
        PH_RX      = 4'd9,
        PH_NAK_L   = 4'd10,
        PH_NAK_H   = 4'd11,
        PH_STOP_A  = 4'd12,
        PH_STOP_B  = 4'd13,
        PH_STOP_C  = 4'd14
    } t_phase;

    logic [7:0] r_dev;
    t_phase     r_ph,   n_ph;
    logic [1:0] r_idx,  n_idx;
    logic       r_pass, n_pass;
    logic [3:0] r_bits, n_bits;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_high, n_high;
    logic [7:0] r_low,  n_low;
    logic [1:0] r_req,  n_req;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_data, n_data;
    logic       r_nack, n_nack;
    logic       r_scl,  n_scl;
    logic       r_sda,  n_sda;

    t_phase     w_ph;
    logic       w_busy;
    logic       w_done;
    logic [15:0] w_rdata;
    logic       w_nseen;

    // byte index 0 device write address, 1 register address, 2 data or read address
    function automatic logic [7:0] byte_to_send(input logic [1:0] idx, input logic pass,
                                                input logic [1:0] req, input logic [7:0] addr,
                                                input logic [7:0] data, input logic [7:0] dev);
        logic [7:0] b;
        if (idx == 2'd0) begin
            b = dev;
        end else if (idx == 2'd1) begin
            b = addr + {7'd0, pass};
        end else if (req == i2cra_pkg::FUNC_WRITE) begin
            b = data;
        end else begin
            b = dev + 8'd1;
        end
        return b;
    endfunction

    always_comb begin
        n_ph    = r_ph;
        n_idx   = r_idx;
        n_pass  = r_pass;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_high  = r_high;
        n_low   = r_low;
        n_req   = r_req;
        n_addr  = r_addr;
        n_data  = r_data;
        n_nack  = r_nack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        w_ph    = r_ph;
        w_done  = 1'b0;
        w_rdata = 16'd0;
        w_nseen = 1'b0;

        if (r_ph == PH_IDLE && i_item.func != i2cra_pkg::FUNC_TICK) begin
            n_req  = i_item.func;
            n_addr = i_item.reg_addr;
            n_data = i_item.write_data;
            n_nack = 1'b0;
            w_ph   = PH_START_A;
            n_idx  = 2'd0;
            n_pass = 1'b0;
        end
        w_busy = (w_ph != PH_IDLE);
        n_ph   = w_ph;

        case (w_ph)
            PH_START_A: begin
                n_scl = 1'b1; n_sda = 1'b1; n_ph = PH_START_B;
            end
            PH_START_B: begin
                n_scl   = 1'b1; n_sda = 1'b0;
                n_idx   = 2'd0;
                n_shift = byte_to_send(2'd0, r_pass, r_req, r_addr, r_data, r_dev);
                n_bits  = 4'd0;
                n_ph    = PH_TX;
            end
            PH_TX: begin
                n_sda = r_shift[7];
                n_scl = r_bits[0];
                if (r_bits[0]) begin
                    n_shift = {r_shift[6:0], 1'b0};
                end
                if (r_bits == 4'd15) begin
                    n_bits = 4'd0;
                    n_ph   = PH_TXACK_L;
                end else begin
                    n_bits = r_bits + 4'd1;
                end
            end
            PH_TXACK_L: begin
                n_scl = 1'b0; n_sda = 1'b1; n_ph = PH_TXACK_H;
            end
            PH_TXACK_H: begin
                n_scl  = 1'b1; n_sda = 1'b1;
                if (i_item.sda_in) begin
                    n_nack = 1'b1;
                end
                n_bits = 4'd0;
                if (r_req == i2cra_pkg::FUNC_WRITE) begin
                    if (r_idx < 2'd2) begin
                        n_idx   = r_idx + 2'd1;
                        n_shift = byte_to_send(r_idx + 2'd1, r_pass, r_req, r_addr,
                                               r_data, r_dev);
                        n_ph    = PH_TX;
                    end else begin
                        n_ph = PH_STOP_A;
                    end
                end else if (r_idx == 2'd0) begin
                    n_idx   = 2'd1;
                    n_shift = byte_to_send(2'd1, r_pass, r_req, r_addr, r_data, r_dev);
                    n_ph    = PH_TX;
                end else if (r_idx == 2'd1) begin
                    n_ph = PH_RS_A;
                end else begin
                    n_shift = 8'd0;
                    n_ph    = PH_RX;
                end
            end
            PH_RS_A: begin
                n_scl = 1'b0; n_sda = 1'b1; n_ph = PH_RS_B;
            end
            PH_RS_B: begin
                n_scl = 1'b1; n_sda = 1'b1; n_ph = PH_RS_C;
            end
            PH_RS_C: begin
                n_scl   = 1'b1; n_sda = 1'b0;
                n_idx   = 2'd2;
                n_shift = byte_to_send(2'd2, r_pass, r_req, r_addr, r_data, r_dev);
                n_bits  = 4'd0;
                n_ph    = PH_TX;
            end
            PH_RX: begin
                n_sda = 1'b1;
                n_scl = r_bits[0];
                if (r_bits[0]) begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                end
                if (r_bits == 4'd15) begin
                    n_bits = 4'd0;
                    if (r_pass) begin
                        n_low = n_shift;
                    end else begin
                        n_high = n_shift;
                    end
                    n_ph = PH_NAK_L;
                end else begin
                    n_bits = r_bits + 4'd1;
                end
            end
            PH_NAK_L: begin
                n_scl = 1'b0; n_sda = 1'b1; n_ph = PH_NAK_H;
            end
            PH_NAK_H: begin
                n_scl = 1'b1; n_sda = 1'b1; n_ph = PH_STOP_A;
            end
            PH_STOP_A: begin
                n_scl = 1'b0; n_sda = 1'b0; n_ph = PH_STOP_B;
            end
            PH_STOP_B: begin
                n_scl = 1'b1; n_sda = 1'b0; n_ph = PH_STOP_C;
            end
            PH_STOP_C: begin
                n_scl = 1'b1; n_sda = 1'b1;
                // first half of a pair read goes straight into the second start
                if (r_req == i2cra_pkg::FUNC_PAIR && !r_pass) begin
                    n_pass = 1'b1; n_idx = 2'd0; n_ph = PH_START_A;
                end else begin
                    w_done  = 1'b1;
                    w_nseen = r_nack;
                    if (r_req == i2cra_pkg::FUNC_READ) begin
                        w_rdata = {8'd0, r_high};
                    end else if (r_req == i2cra_pkg::FUNC_PAIR) begin
                        w_rdata = {r_high, r_low};
                    end
                    n_pass = 1'b0; n_idx = 2'd0; n_ph = PH_IDLE;
                end
            end
            default: begin
                n_ph = PH_IDLE; n_idx = 2'd0; n_pass = 1'b0;
            end
        endcase
    end

    assign o_res.scl       = n_scl;
    assign o_res.sda       = n_sda;
    assign o_res.busy_res  = w_busy;
    assign o_res.done_res  = w_done;
    assign o_res.read_data = w_rdata;
    assign o_res.nack_seen = w_nseen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev   <= 8'd0;
            r_ph    <= PH_IDLE;
            r_idx   <= 2'd0;
            r_pass  <= 1'b0;
            r_bits  <= 4'd0;
            r_shift <= 8'd0;
            r_high  <= 8'd0;
            r_low   <= 8'd0;
            r_req   <= 2'd0;
            r_addr  <= 8'd0;
            r_data  <= 8'd0;
            r_nack  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_dev <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_ph    <= n_ph;
                r_idx   <= n_idx;
                r_pass  <= n_pass;
                r_bits  <= n_bits;
                r_shift <= n_shift;
                r_high  <= n_high;
                r_low   <= n_low;
                r_req   <= n_req;
                r_addr  <= n_addr;
                r_data  <= n_data;
                r_nack  <= n_nack;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
            end
        end
    end

endmodule

// ----- rtl/core/i2cra_out_stage.sv -----
// result register in front of the result channel
module i2cra_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  i2cra_pkg::t_out_item i_res,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output i2cra_pkg::t_out_item o_item
);

    logic                 r_vld;
    i2cra_pkg::t_out_item r_item;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

endmodule

// ----- rtl/core/i2c_register_access_master.sv -----
// top level of the i2c register access master
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_in_data  (t_in_item, one slot)
//  out       output     o_out_valid / i_out_ready o_out_data (t_out_item, one slot)
//  cfg       input      i_cfg_we                  i_cfg_wdata (device write address)
//
// one slot in, one slot out, one per cycle sustained while the output is not stalled
// path: input register, then sequencer step into the result register
// the sequencer state advances only when a slot moves from the input register
// into the result register; a stalled output holds both stages
// synchronous active-low reset releases both lines and returns the sequencer to idle
module i2c_register_access_master (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  i2cra_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output i2cra_pkg::t_out_item o_out_data
);

    logic                 w_in_vld;
    i2cra_pkg::t_in_item  w_in_item;
    logic                 w_out_free;
    logic                 w_fire;
    i2cra_pkg::t_out_item w_res;

    assign w_fire = w_in_vld && w_out_free;

    i2cra_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_take  (w_fire),
        .o_valid (w_in_vld),
        .o_item  (w_in_item)
    );

    i2cra_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_item      (w_in_item),
        .o_res       (w_res)
    );

    i2cra_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

`ifndef SYNTHESIS
    // every step taken lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("sequencer step lost before the result register");

    // a finished transaction is still reported busy in its last slot
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> o_out_data.busy_res)
        else $error("done without busy");

    // read data and nack only show in the final slot
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |->
            (o_out_data.read_data == 16'd0) && !o_out_data.nack_seen)
        else $error("result fields set outside the final slot");
`endif

endmodule
